// ===== rtl/core/bsoc_pkg.sv =====
package bsoc_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int IDX_W       = (TABLE_DEPTH > 2) ? $clog2(TABLE_DEPTH) : 1;

   localparam int NUM_W       = 64;
   localparam int DEN_W       = 42;
   localparam int DELTA_W     = DEN_W + 1;
   localparam int DIV_CNT_W   = $clog2(NUM_W + 1);

   localparam logic [21:0] MS_PER_HOUR = 22'd3600000;

   localparam logic [1:0] OP_LOAD = 2'd0;
   localparam logic [1:0] OP_INIT = 2'd1;
   localparam logic [1:0] OP_TICK = 2'd2;

   localparam logic [1:0] CSR_PERIOD   = 2'd0;
   localparam logic [1:0] CSR_CAPACITY = 2'd1;
   localparam logic [1:0] CSR_ENTRIES  = 2'd2;

   typedef enum logic [1:0] {
      RD_MID  = 2'd0,
      RD_LO   = 2'd1,
      RD_PREV = 2'd2
   } bsoc_rd_sel_type;

   typedef struct packed {
      logic            capture;
      logic            mem_wr;
      logic            rd_en;
      bsoc_rd_sel_type rd_sel;
      logic            step_search;
      logic            save_low;
      logic            save_high;
      logic            accum_clamp;
      logic            mul_load;
      logic            mul_tick;
      logic            div_start;
      logic            accum_init;
      logic            accum_tick;
      logic            rsp_load;
   } bsoc_cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       lo_lt_hi;
      logic       lo_zero;
      logic       rd_gt_v;
      logic       div_busy;
   } bsoc_sts_type;

   function automatic logic [IDX_W-1:0] last_index(input logic [4:0] entries);
      if (entries < 5'd2) begin
         return IDX_W'(1);
      end else if (int'(entries) > TABLE_DEPTH) begin
         return IDX_W'(TABLE_DEPTH - 1);
      end else begin
         return IDX_W'(int'(entries) - 1);
      end
   endfunction

endpackage

// ===== rtl/core/bsoc_div.sv =====
module bsoc_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [bsoc_pkg::NUM_W-1:0]   num,
   input  logic [bsoc_pkg::DEN_W-1:0]   den,
   output logic                         busy,
   output logic [bsoc_pkg::NUM_W-1:0]   quot
);
   import bsoc_pkg::*;

   logic [DEN_W-1:0]     rem_ff, rem_in;
   logic [NUM_W-1:0]     quo_ff, quo_in;
   logic [DEN_W-1:0]     den_ff, den_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DEN_W:0]       shifted;
   logic [DEN_W:0]       diff;
   logic                 fits;

   assign shifted = {rem_ff, quo_ff[NUM_W-1]};
   assign diff    = shifted - {1'b0, den_ff};
   assign fits    = shifted >= {1'b0, den_ff};

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      den_in = den_ff;
      cnt_in = cnt_ff;
      if (start) begin
         rem_in = '0;
         quo_in = num;
         den_in = den;
         cnt_in = DIV_CNT_W'(NUM_W);
      end else if (busy) begin
         rem_in = fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
         quo_in = {quo_ff[NUM_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign busy = cnt_ff != '0;
   assign quot = quo_ff;

endmodule

// ===== rtl/core/bsoc_dpath.sv =====
module bsoc_dpath (
   input  logic                  clock,
   input  logic                  reset,
   input  bsoc_pkg::bsoc_cmd_type cmd,
   output bsoc_pkg::bsoc_sts_type sts,
   input  logic [1:0]            req_operation,
   input  logic [3:0]            req_entry_index,
   input  logic [14:0]           req_entry_voltage_mv,
   input  logic [15:0]           req_entry_charge,
   input  logic [14:0]           req_battery_voltage_mv,
   input  logic signed [15:0]    req_battery_current_ma,
   output logic [15:0]           rsp_charge_fraction,
   input  logic                  csr_valid,
   input  logic [1:0]            csr_index,
   input  logic [19:0]           csr_wdata
);
   import bsoc_pkg::*;

   logic [14:0] vmem [TABLE_DEPTH];
   logic [15:0] cmem [TABLE_DEPTH];

   logic [15:0] period_ff;
   logic [19:0] capacity_ff;
   logic [4:0]  entries_ff;

   logic [1:0]  op_ff;
   logic [3:0]  idx_ff;
   logic [14:0] ev_ff;
   logic [15:0] ec_ff;
   logic [14:0] bv_ff;
   logic [15:0] cur_ff;

   logic [IDX_W-1:0] lo_ff, hi_ff, mid, rd_addr;
   logic [14:0] rd_v_ff, v1_ff, v2_ff;
   logic [15:0] rd_c_ff, c1_ff, c2_ff;
   logic        up_ff;
   logic [NUM_W-1:0] num_ff;
   logic [DEN_W-1:0] den_ff;
   logic [31:0] accum_ff, accum_in;
   logic [15:0] rsp_ff;

   logic [14:0] dv;
   logic [15:0] dc;
   logic [30:0] prod_init;
   logic [15:0] mag_i;
   logic [19:0] cap_eff;
   logic [31:0] prod_tick;
   logic [DEN_W-1:0] den_tick;
   logic [NUM_W-1:0] quot;
   logic        div_busy;
   logic [DELTA_W-1:0] delta;
   logic [31:0] base;
   logic [31:0] headroom;

   bsoc_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (num_ff),
      .den   (den_ff),
      .busy  (div_busy),
      .quot  (quot)
   );

   assign mid = lo_ff + ((hi_ff - lo_ff) >> 1);

   always_comb begin
      case (cmd.rd_sel)
         RD_MID:  rd_addr = mid;
         RD_LO:   rd_addr = lo_ff;
         RD_PREV: rd_addr = lo_ff - 1'b1;
         default: rd_addr = lo_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_wr && (int'(idx_ff) < TABLE_DEPTH)) begin
         vmem[IDX_W'(idx_ff)] <= ev_ff;
         cmem[IDX_W'(idx_ff)] <= ec_ff;
      end
      if (cmd.rd_en) begin
         rd_v_ff <= vmem[rd_addr];
         rd_c_ff <= cmem[rd_addr];
      end
   end

   assign dv        = v1_ff - bv_ff;
   assign dc        = up_ff ? (c2_ff - c1_ff) : (c1_ff - c2_ff);
   assign prod_init = {16'd0, dv} * {15'd0, dc};
   assign mag_i     = cur_ff[15] ? (~cur_ff + 16'd1) : cur_ff;
   assign cap_eff   = (capacity_ff == 20'd0) ? 20'd1 : capacity_ff;
   assign prod_tick = {16'd0, mag_i} * {16'd0, period_ff};
   assign den_tick  = {22'd0, cap_eff} * {20'd0, MS_PER_HOUR};

   assign delta    = quot[DELTA_W-1:0];
   assign base     = {c1_ff, 16'd0};
   assign headroom = ~accum_ff;

   always_comb begin
      accum_in = accum_ff;
      if (cmd.accum_clamp) begin
         accum_in = {rd_c_ff, 16'd0};
      end else if (cmd.accum_init) begin
         accum_in = up_ff ? (base + quot[31:0]) : (base - quot[31:0]);
      end else if (cmd.accum_tick) begin
         if (!cur_ff[15]) begin
            accum_in = (delta >= {11'd0, accum_ff}) ? 32'd0 : (accum_ff - delta[31:0]);
         end else begin
            accum_in = (delta >= {11'd0, headroom}) ? 32'hFFFF_FFFF
                                                     : (accum_ff + delta[31:0]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff   <= 16'd1000;
         capacity_ff <= 20'd2000;
         entries_ff  <= 5'd16;
         accum_ff    <= '0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               CSR_PERIOD:   period_ff   <= csr_wdata[15:0];
               CSR_CAPACITY: capacity_ff <= csr_wdata;
               CSR_ENTRIES:  entries_ff  <= csr_wdata[4:0];
               default: ;
            endcase
         end
         accum_ff <= accum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff  <= req_operation;
         idx_ff <= req_entry_index;
         ev_ff  <= req_entry_voltage_mv;
         ec_ff  <= req_entry_charge;
         bv_ff  <= req_battery_voltage_mv;
         cur_ff <= req_battery_current_ma;
         lo_ff  <= '0;
         hi_ff  <= last_index(entries_ff);
      end else if (cmd.step_search) begin
         if (rd_v_ff > bv_ff) begin
            lo_ff <= mid + 1'b1;
         end else begin
            hi_ff <= mid;
         end
      end
      if (cmd.save_low) begin
         v2_ff <= rd_v_ff;
         c2_ff <= rd_c_ff;
      end
      if (cmd.save_high) begin
         v1_ff <= rd_v_ff;
         c1_ff <= rd_c_ff;
         up_ff <= c2_ff >= rd_c_ff;
      end
      if (cmd.mul_load) begin
         if (cmd.mul_tick) begin
            num_ff <= {prod_tick, 32'd0};
            den_ff <= den_tick;
         end else begin
            num_ff <= {17'd0, prod_init, 16'd0};
            den_ff <= {27'd0, v1_ff - v2_ff};
         end
      end
      if (cmd.rsp_load) begin
         rsp_ff <= accum_ff[31:16];
      end
   end

   assign sts.op       = op_ff;
   assign sts.lo_lt_hi = lo_ff < hi_ff;
   assign sts.lo_zero  = lo_ff == '0;
   assign sts.rd_gt_v  = rd_v_ff > bv_ff;
   assign sts.div_busy = div_busy;

   assign rsp_charge_fraction = rsp_ff;

endmodule

// ===== rtl/core/bsoc_ctrl.sv =====
module bsoc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  bsoc_pkg::bsoc_sts_type sts,
   output bsoc_pkg::bsoc_cmd_type cmd
);
   import bsoc_pkg::*;

   typedef enum logic [11:0] {
      ST_IDLE     = 12'b0000_0000_0001,
      ST_WRITE    = 12'b0000_0000_0010,
      ST_SRCH     = 12'b0000_0000_0100,
      ST_CMP      = 12'b0000_0000_1000,
      ST_CHK_LO   = 12'b0000_0001_0000,
      ST_RD_PREV  = 12'b0000_0010_0000,
      ST_CHK_PREV = 12'b0000_0100_0000,
      ST_MUL      = 12'b0000_1000_0000,
      ST_DIV_GO   = 12'b0001_0000_0000,
      ST_DIV_WAIT = 12'b0010_0000_0000,
      ST_APPLY    = 12'b0100_0000_0000,
      ST_OUT      = 12'b1000_0000_0000
   } bsoc_state_type;

   bsoc_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;

   assign req_ready = state_ff == ST_IDLE;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      cmd.rd_sel = RD_LO;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               case (sts.op)
                  OP_LOAD: state_in = ST_WRITE;
                  OP_INIT: state_in = ST_SRCH;
                  OP_TICK: state_in = ST_MUL;
                  default: state_in = ST_OUT;
               endcase
            end
         end
         ST_WRITE: begin
            cmd.mem_wr = 1'b1;
            state_in   = ST_OUT;
         end
         ST_SRCH: begin
            cmd.rd_en = 1'b1;
            if (sts.lo_lt_hi) begin
               cmd.rd_sel = RD_MID;
               state_in   = ST_CMP;
            end else begin
               cmd.rd_sel = RD_LO;
               state_in   = ST_CHK_LO;
            end
         end
         ST_CMP: begin
            cmd.step_search = 1'b1;
            state_in        = ST_SRCH;
         end
         ST_CHK_LO: begin
            if (sts.lo_zero || sts.rd_gt_v) begin
               cmd.accum_clamp = 1'b1;
               state_in        = ST_OUT;
            end else begin
               cmd.save_low = 1'b1;
               state_in     = ST_RD_PREV;
            end
         end
         ST_RD_PREV: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_PREV;
            state_in   = ST_CHK_PREV;
         end
         ST_CHK_PREV: begin
            if (!sts.rd_gt_v) begin
               cmd.accum_clamp = 1'b1;
               state_in        = ST_OUT;
            end else begin
               cmd.save_high = 1'b1;
               state_in      = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul_load = 1'b1;
            cmd.mul_tick = sts.op == OP_TICK;
            state_in     = ST_DIV_GO;
         end
         ST_DIV_GO: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (!sts.div_busy) begin
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            cmd.accum_tick = sts.op == OP_TICK;
            cmd.accum_init = sts.op != OP_TICK;
            state_in       = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("pending result overwritten");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("item accepted while previous item in flight");

   a_div_idle_start: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> !sts.div_busy)
      else $error("divider restarted while busy");

   a_one_update: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.accum_clamp, cmd.accum_init, cmd.accum_tick}))
      else $error("conflicting charge updates");

   a_load_then_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |=> rsp_valid)
      else $error("loaded result not presented");

endmodule

// ===== rtl/core/battery_soc_estimator_unit.sv =====
// Battery state-of-charge estimator: voltage table lookup plus coulomb counting.
// Request channel (req_valid/req_ready) carries one item per handshake: load a
// table slot, initialize the charge from a measured voltage, or apply one
// coulomb-counting tick. Every item returns one item on the response channel
// (rsp_valid/rsp_ready) holding the upper 16 bits of the 32-bit charge.
// The csr channel writes sample period, capacity and table entry count and is
// always ready; write it only while the block is idle (not enforced here).
// One item is worked on at a time. A load writes the table slot and an unused
// code goes straight to the response; a tick runs the one-bit-per-cycle
// 64-step divider; an initialize binary-searches the table against the
// registered read port, then runs the divider unless the charge is clamped
// to a table entry. The next item is accepted in the cycle after the response
// is loaded.
// The response sits in an output register: while the receiver stalls the block
// still accepts and works the next item, and holds before loading its result
// until the pending one is taken.
// Reset clears the charge to zero and restores the csr defaults; table
// contents are undefined until loaded.
module battery_soc_estimator_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_operation,
   input  logic [3:0]         req_entry_index,
   input  logic [14:0]        req_entry_voltage_mv,
   input  logic [15:0]        req_entry_charge,
   input  logic [14:0]        req_battery_voltage_mv,
   input  logic signed [15:0] req_battery_current_ma,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [15:0]        rsp_charge_fraction,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [19:0]        csr_wdata
);
   import bsoc_pkg::*;

   bsoc_cmd_type cmd;
   bsoc_sts_type sts;
   bsoc_sts_type sts_ctrl;

   assign csr_ready = 1'b1;

   always_comb begin
      sts_ctrl = sts;
      if (req_ready) begin
         sts_ctrl.op = req_operation;
      end
   end

   bsoc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts_ctrl),
      .cmd       (cmd)
   );

   bsoc_dpath u_dpath (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .sts                    (sts),
      .req_operation          (req_operation),
      .req_entry_index        (req_entry_index),
      .req_entry_voltage_mv   (req_entry_voltage_mv),
      .req_entry_charge       (req_entry_charge),
      .req_battery_voltage_mv (req_battery_voltage_mv),
      .req_battery_current_ma (req_battery_current_ma),
      .rsp_charge_fraction    (rsp_charge_fraction),
      .csr_valid              (csr_valid),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata)
   );

endmodule
